### hw/rtl/utf8_decoder_replace_unit_macros.svh
// Assertion macros for the UTF-8 decoder with replacement.
// Every macro samples on clk and is disabled while rst is high.
`ifndef UTF8_DECODER_REPLACE_UNIT_MACROS_SVH
`define UTF8_DECODER_REPLACE_UNIT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define U8R_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utf8 decoder: assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define U8R_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utf8 decoder: assertion failed");

`endif

### hw/rtl/u8r_pkg.sv
// Shared types and constants for the UTF-8 decoder with replacement.
// No dependencies; used by every module of the block.
`default_nettype none

package u8r_pkg;

  // Default depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Decode window: up to three held bytes plus the new one.
  localparam int WIN_DEPTH = 4;

  // Code point constants.
  localparam logic [20:0] REPL_CP = 21'h00FFFD;
  localparam logic [20:0] MAX_CP  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2 = 21'h000080;
  localparam logic [20:0] MIN_CP3 = 21'h000800;
  localparam logic [20:0] MIN_CP4 = 21'h010000;

  // Byte pattern masks and tags.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Class of a raw byte as seen by the front end.
  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_CONT,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  // One byte of the decode window.
  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
  } win_entry_t;

  // One request as it travels through the queue.
  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        eoi;
  } byte_item_t;

endpackage

`default_nettype wire

### hw/rtl/u8r_front.sv
// Front end: accepts input requests, classifies each byte and hands it to the queue.
// Depends on u8r_pkg.
`default_nettype none

module u8r_front
  import u8r_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            push,
  output byte_item_t      push_item,
  input  wire logic       q_full
);

  logic        stage_valid;
  logic        stage_valid_next;
  byte_item_t  stage_item;
  byte_class_t cls;
  logic        accept;

  // Classify the incoming byte by its leading bits.
  always_comb begin
    if (!in_byte[7]) begin
      cls = CLS_ASCII;
    end else if ((in_byte & CONT_MASK) == CONT_TAG) begin
      cls = CLS_CONT;
    end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
      cls = CLS_LEAD2;
    end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
      cls = CLS_LEAD3;
    end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
  end

  // The stage register drains into the queue whenever the queue has room.
  assign push      = stage_valid && !q_full;
  assign push_item = stage_item;
  assign in_stall  = stage_valid && q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    stage_valid_next = accept || (stage_valid && !push);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  // Payload register, loaded on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item <= '{data: in_byte, cls: cls, eoi: end_of_input};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u8r_queue.sv
// Short first-in first-out queue of classified bytes between front and back ends.
// Depends on u8r_pkg.
`default_nettype none

module u8r_queue
  import u8r_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire byte_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output byte_item_t      head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  byte_item_t     slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  wr_ptr_next;
  logic [AW-1:0]  rd_ptr;
  logic [AW-1:0]  rd_ptr_next;
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  // Pointer wrap and occupancy update.
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/u8r_back.sv
// Back end: decode window, one code point per cycle unless the output stalls, result hold and output register.
// Depends on u8r_pkg and the assertion macros header.
`default_nettype none
`include "utf8_decoder_replace_unit_macros.svh"

module u8r_back
  import u8r_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        head_valid,
  input  wire byte_item_t  head_item,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      code_point,
  output logic             replaced,
  output logic             last_of_run
);

  // Window of held bytes, oldest first.
  win_entry_t  win      [WIN_DEPTH];
  win_entry_t  win_next [WIN_DEPTH];
  logic [2:0]  cnt;
  logic [2:0]  cnt_next;
  logic        eoi;
  logic        eoi_next;
  logic        active;
  logic        active_next;

  // Result waiting until the next decode tells whether it ends the run.
  logic        hold_valid;
  logic        hold_valid_next;
  logic [20:0] hold_cp;
  logic [20:0] hold_cp_next;
  logic        hold_rep;
  logic        hold_rep_next;

  // Decode of the window front.
  logic [1:0]  extra;
  logic        multi_lead;
  logic        scan_short;
  logic        scan_bad;
  logic [20:0] cp_raw;
  logic        cp_illegal;
  logic        dec_emit;
  logic        dec_rep;
  logic [2:0]  dec_used;
  logic [20:0] dec_cp;

  logic        out_free;
  logic        step_ok;
  logic        out_load;
  logic        out_last;

  // Number of continuation bytes the lead byte asks for.
  always_comb begin
    case (win[0].cls)
      CLS_LEAD2: extra = 2'd1;
      CLS_LEAD3: extra = 2'd2;
      CLS_LEAD4: extra = 2'd3;
      default:   extra = 2'd0;
    endcase
  end

  assign multi_lead = (win[0].cls == CLS_LEAD2) || (win[0].cls == CLS_LEAD3) ||
                      (win[0].cls == CLS_LEAD4);

  // Scan continuations in order; the first missing or bad byte decides.
  always_comb begin
    logic done;
    done       = 1'b0;
    scan_short = 1'b0;
    scan_bad   = 1'b0;
    for (int i = 1; i < WIN_DEPTH; i++) begin
      if (!done && (2'(i) <= extra)) begin
        if (3'(i) >= cnt) begin
          scan_short = 1'b1;
          done       = 1'b1;
        end else if (win[i].cls != CLS_CONT) begin
          scan_bad = 1'b1;
          done     = 1'b1;
        end
      end
    end
  end

  // Assemble the code point from the payload bits.
  always_comb begin
    case (extra)
      2'd1:    cp_raw = {10'd0, win[0].data[4:0], win[1].data[5:0]};
      2'd2:    cp_raw = {5'd0, win[0].data[3:0], win[1].data[5:0], win[2].data[5:0]};
      2'd3:    cp_raw = {win[0].data[2:0], win[1].data[5:0], win[2].data[5:0],
                         win[3].data[5:0]};
      default: cp_raw = {13'd0, win[0].data};
    endcase
  end

  // Overlong forms, surrogates and values beyond the Unicode range.
  always_comb begin
    cp_illegal = ((extra == 2'd1) && (cp_raw < MIN_CP2)) ||
                 ((extra == 2'd2) && (cp_raw < MIN_CP3)) ||
                 ((extra == 2'd3) && (cp_raw < MIN_CP4)) ||
                 ((cp_raw >= SURR_LO) && (cp_raw <= SURR_HI)) ||
                 (cp_raw > MAX_CP);
  end

  // A truncated sequence waits for more bytes unless the buffer has ended.
  always_comb begin
    dec_emit = (cnt != 3'd0) && !(multi_lead && scan_short && !eoi);
    dec_rep  = (win[0].cls == CLS_CONT) || (win[0].cls == CLS_BAD) || scan_bad ||
               (scan_short && eoi) ||
               (multi_lead && !scan_short && !scan_bad && cp_illegal);
    dec_used = dec_rep ? 3'd1 : {1'b0, extra} + 3'd1;
    dec_cp   = dec_rep ? REPL_CP : cp_raw;
  end

  // A step can move only if the held result can go to the output register.
  assign out_free = !out_valid || !out_stall;
  assign step_ok  = !hold_valid || out_free;

  // Sequencer: load a byte, emit results one per cycle unless the output stalls, close the run.
  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_next[i] = win[i];
    end
    cnt_next        = cnt;
    eoi_next        = eoi;
    active_next     = active;
    hold_valid_next = hold_valid;
    hold_cp_next    = hold_cp;
    hold_rep_next   = hold_rep;
    pop             = 1'b0;
    out_load        = 1'b0;
    out_last        = 1'b0;

    if (active && dec_emit) begin
      if (step_ok) begin
        out_load        = hold_valid;
        hold_valid_next = 1'b1;
        hold_cp_next    = dec_cp;
        hold_rep_next   = dec_rep;
        cnt_next        = cnt - dec_used;
        case (dec_used)
          3'd1: begin
            win_next[0] = win[1];
            win_next[1] = win[2];
            win_next[2] = win[3];
          end
          3'd2: begin
            win_next[0] = win[2];
            win_next[1] = win[3];
          end
          3'd3: begin
            win_next[0] = win[3];
          end
          default: begin
          end
        endcase
      end
    end else if (!active || step_ok) begin
      // Close the run (if any) and take the next byte in the same cycle.
      if (active) begin
        out_load        = hold_valid;
        out_last        = 1'b1;
        hold_valid_next = 1'b0;
        active_next     = 1'b0;
      end
      if (head_valid) begin
        pop                  = 1'b1;
        win_next[cnt[1:0]]   = '{data: head_item.data, cls: head_item.cls};
        cnt_next             = cnt + 3'd1;
        eoi_next             = head_item.eoi;
        active_next          = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= 3'd0;
      eoi        <= 1'b0;
      active     <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cnt        <= cnt_next;
      eoi        <= eoi_next;
      active     <= active_next;
      hold_valid <= hold_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Window, held result and output payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win[i] <= win_next[i];
    end
    hold_cp  <= hold_cp_next;
    hold_rep <= hold_rep_next;
    if (out_load) begin
      code_point  <= hold_cp;
      replaced    <= hold_rep;
      last_of_run <= out_last;
    end
  end

  // Between requests at most three bytes stay held.
  `U8R_ASSERT_IMP(a_idle_room, !active, cnt <= 3'd3)
  // A result is only held while a request is being decoded.
  `U8R_ASSERT_IMP(a_hold_in_step, hold_valid, active)
  // At the end of the buffer nothing is held back for more bytes.
  `U8R_ASSERT_IMP(a_eoi_no_wait, active && eoi && (cnt != 3'd0), dec_emit)
  // Every emitted result consumes at least one window byte.
  `U8R_ASSERT_NXT(a_emit_shrinks, active && dec_emit && step_ok, cnt < $past(cnt))

endmodule

`default_nettype wire

### hw/rtl/utf8_decoder_replace_unit.sv
// UTF-8 decoder with U+FFFD replacement. The decoder loads each accepted byte, emits the
// code points that it yields one after another, and closes the run while it loads the
// next byte; a byte that is only held is just loaded.
// Synchronous reset empties the front stage, the queue and the decode window; the
// held-byte storage itself is not cleared.
`default_nettype none

module utf8_decoder_replace_unit
  import u8r_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [20:0]      code_point,
  output logic             replaced,
  output logic             last_of_run
);

  logic       push;
  byte_item_t push_item;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  byte_item_t head_item;

  // Front end: input register and byte classification.
  u8r_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .push         (push),
    .push_item    (push_item),
    .q_full       (q_full)
  );

  // Queue decoupling the two ends.
  u8r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // Back end: decode window and result output.
  u8r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_item   (head_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_point  (code_point),
    .replaced    (replaced),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

### test/utf8_decoder_replace_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_decoder_replace_unit, a byte-in, code-point-out decoder.
// Depends on u8r_pkg for the byte masks and code point constants, and on the RTL top level.

module utf8_decoder_replace_unit_tb;
  import u8r_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [20:0] cp;
    logic        rep;
    logic        last;
  } cp_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [20:0] code_point;
  logic        replaced;
  logic        last_of_run;

  // Code points the decoder owes us, oldest first.
  cp_result_t  expected_cps[$];

  // Bytes of an unfinished sequence as the decoder should hold them.
  logic [7:0]  held_bytes[3];
  int          held_cnt;

  // Scratch buffer for one generated character.
  logic [7:0]  char_buf[4];
  int          char_len;

  bit          idle_en;
  bit          hold_req;
  int          stall_left;
  int          hold_left;
  int          cycle_cnt;
  int          bytes_sent;
  int          cps_checked;
  int          repl_seen;
  int          mismatch_cnt;

  utf8_decoder_replace_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_point   (code_point),
    .replaced     (replaced),
    .last_of_run  (last_of_run)
  );

  // Free-running 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decode one accepted byte against the held window and queue every code point it yields.
  task automatic decode_byte(input logic [7:0] b, input logic eoi);
    logic [7:0]  win[4];
    logic [7:0]  c;
    logic [7:0]  cc;
    logic [20:0] cp;
    cp_result_t  step_res[4];
    int          n;
    int          pos;
    int          avail;
    int          extra;
    int          used;
    int          nres;
    int          i;
    bit          rep;
    bit          stop;
    begin
      n = held_cnt;
      for (i = 0; i < n; i++) win[i] = held_bytes[i];
      win[n] = b;
      n++;
      pos = 0;
      nres = 0;
      stop = 1'b0;
      while (pos < n && !stop) begin
        c = win[pos];
        avail = n - pos;
        extra = 0;
        used = 1;
        cp = '0;
        rep = 1'b0;
        if (c < 8'h80) begin
          cp = {13'd0, c};
        end else begin
          if ((c & LEAD2_MASK) == LEAD2_TAG) begin
            extra = 1;
            cp = {16'd0, c[4:0]};
          end else if ((c & LEAD3_MASK) == LEAD3_TAG) begin
            extra = 2;
            cp = {17'd0, c[3:0]};
          end else if ((c & LEAD4_MASK) == LEAD4_TAG) begin
            extra = 3;
            cp = {18'd0, c[2:0]};
          end else begin
            rep = 1'b1;
          end
          // Gather continuation bytes; a missing one either waits or, at the end, fails.
          if (!rep) begin
            for (i = 1; i <= extra; i++) begin
              if (i >= avail) begin
                if (eoi) rep = 1'b1;
                else stop = 1'b1;
                break;
              end
              cc = win[pos + i];
              if ((cc & CONT_MASK) != CONT_TAG) begin
                rep = 1'b1;
                break;
              end
              cp = (cp << 6) | {15'd0, cc[5:0]};
            end
          end
          // A complete sequence must be shortest form, not a surrogate, and in range.
          if (!stop && !rep) begin
            if ((extra == 1 && cp < MIN_CP2) || (extra == 2 && cp < MIN_CP3) ||
                (extra == 3 && cp < MIN_CP4))
              rep = 1'b1;
            else if (cp >= SURR_LO && cp <= SURR_HI)
              rep = 1'b1;
            else if (cp > MAX_CP)
              rep = 1'b1;
            else
              used = 1 + extra;
          end
        end
        if (!stop) begin
          if (rep) begin
            cp = REPL_CP;
            used = 1;
          end
          step_res[nres] = '{cp: cp, rep: rep, last: 1'b0};
          nres++;
          pos += used;
        end
      end
      if (nres > 0) step_res[nres - 1].last = 1'b1;
      for (i = 0; i < nres; i++) expected_cps.push_back(step_res[i]);
      held_cnt = n - pos;
      for (i = 0; i < held_cnt; i++) held_bytes[i] = win[pos + i];
    end
  endtask

  // Offer one byte, wait for the request to be taken, then predict what it yields.
  task automatic send_byte(input logic [7:0] b, input logic eoi);
    int gap;
    begin
      gap = 0;
      if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
      @(negedge clk);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      in_byte = b;
      end_of_input = eoi;
      do @(posedge clk); while (in_stall);
      decode_byte(b, eoi);
      bytes_sent++;
    end
  endtask

  // Fill char_buf with one character of the given length; bend picks an illegal value for lengths above one.
  task automatic build_char(input int len, input bit bend);
    logic [20:0] cp;
    begin
      char_len = len;
      case (len)
        1: begin
          cp = 21'($urandom_range(0, 8'h7F));
          char_buf[0] = cp[7:0];
        end
        2: begin
          cp = bend ? 21'($urandom_range(0, 8'h7F)) : 21'($urandom_range(8'h80, 12'h7FF));
          char_buf[0] = {3'b110, cp[10:6]};
          char_buf[1] = {2'b10, cp[5:0]};
        end
        3: begin
          if (bend) cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 12'h7FF))
                                              : 21'($urandom_range(16'hD800, 16'hDFFF));
          else cp = 21'($urandom_range(12'h800, 16'hFFFF));
          char_buf[0] = {4'b1110, cp[15:12]};
          char_buf[1] = {2'b10, cp[11:6]};
          char_buf[2] = {2'b10, cp[5:0]};
        end
        default: begin
          if (bend) cp = $urandom_range(0, 1) ? 21'($urandom_range(0, 16'hFFFF))
                                              : 21'($urandom_range(21'h110000, 21'h1FFFFF));
          else cp = 21'($urandom_range(17'h10000, 21'h10FFFF));
          char_buf[0] = {5'b11110, cp[20:18]};
          char_buf[1] = {2'b10, cp[17:12]};
          char_buf[2] = {2'b10, cp[11:6]};
          char_buf[3] = {2'b10, cp[5:0]};
        end
      endcase
    end
  endtask

  // One random unit of text: mostly well-formed characters, some broken, some noise.
  task automatic send_random_unit();
    int kind;
    int i;
    int cut;
    begin
      kind = $urandom_range(0, 99);
      build_char($urandom_range(1, 4), $urandom_range(0, 7) == 0);
      if (kind < 60) begin
        for (i = 0; i < char_len; i++)
          send_byte(char_buf[i], i == char_len - 1 && $urandom_range(0, 19) == 0);
      end else if (kind < 75) begin
        // Corrupt one byte or drop the tail, then carry on without an end flag.
        if ($urandom_range(0, 1)) char_buf[$urandom_range(0, char_len - 1)] = 8'($urandom);
        else if (char_len > 1) char_len = $urandom_range(1, char_len - 1);
        for (i = 0; i < char_len; i++) send_byte(char_buf[i], 1'b0);
      end else if (kind < 85) begin
        // Sequence cut off by the end of the buffer.
        cut = (char_len > 1) ? $urandom_range(1, char_len - 1) : 1;
        for (i = 0; i < cut; i++) send_byte(char_buf[i], i == cut - 1);
      end else begin
        send_byte(8'($urandom), $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall = 1'b1;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare every accepted code point with the oldest expectation.
  always @(posedge clk) begin
    cp_result_t exp_cp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected result: code_point %h replaced %b last_of_run %b",
               code_point, replaced, last_of_run);
        mismatch_cnt++;
      end else begin
        exp_cp = expected_cps.pop_front();
        cps_checked++;
        if (exp_cp.rep) repl_seen++;
        if (code_point !== exp_cp.cp) begin
          $error("code_point mismatch: expected %h, actual %h", exp_cp.cp, code_point);
          mismatch_cnt++;
        end
        if (replaced !== exp_cp.rep) begin
          $error("replaced mismatch: expected %b, actual %b", exp_cp.rep, replaced);
          mismatch_cnt++;
        end
        if (last_of_run !== exp_cp.last) begin
          $error("last_of_run mismatch: expected %b, actual %b", exp_cp.last, last_of_run);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             expected_cps.size());
    $display("utf8_decoder_replace_unit regression: fail");
    $finish;
  end

  // Boundary ASCII values.
  task automatic test_ascii_extremes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  // Shortest and longest legal multi-byte forms.
  task automatic test_valid_sequences();
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF4, 1'b0);
    send_byte(8'h8F, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // A stray continuation byte and an 0xFF byte, which is never a lead.
  task automatic test_invalid_leads();
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // A lead followed by ASCII; the ASCII byte must be rescanned.
  task automatic test_bad_continuation();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  // Overlong two-byte form; its continuation then stands alone.
  task automatic test_overlong_form();
    send_byte(8'hC1, 1'b0);
    send_byte(8'hBF, 1'b0);
  endtask

  // Encoded surrogate: three replacements from the final byte.
  task automatic test_surrogate();
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Value above the Unicode range: four replacements from the final byte.
  task automatic test_above_max();
    send_byte(8'hF4, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  // Sequence cut off by the end flag; everything held is flushed.
  task automatic test_cut_off();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Random text with idling on both sides.
  task automatic test_random_text(input int n_bytes);
    int stop_at;
    begin
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_random_unit();
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure(input int n_bytes);
    int stop_at;
    begin
      hold_req = 1'b1;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) send_random_unit();
    end
  endtask

  // Back-to-back traffic with no idling at all.
  task automatic test_no_idle(input int n_bytes);
    begin
      idle_en = 1'b0;
      test_random_text(n_bytes);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'h00;
    end_of_input = 1'b0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    held_cnt = 0;
    bytes_sent = 0;
    cps_checked = 0;
    repl_seen = 0;
    mismatch_cnt = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ascii_extremes();
    test_valid_sequences();
    test_invalid_leads();
    test_bad_continuation();
    test_overlong_form();
    test_surrogate();
    test_above_max();
    test_cut_off();
    test_random_text(360);
    test_output_backpressure(40);
    test_no_idle(100);

    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then give the block time to show any stray result.
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes, checked %0d code points of which %0d were replacements",
             bytes_sent, cps_checked, repl_seen);
    if (mismatch_cnt == 0) begin
      $display("utf8_decoder_replace_unit regression: pass");
    end else begin
      $display("utf8_decoder_replace_unit regression: fail");
    end
    $finish;
  end

endmodule

### utf8_decoder_replace_unit.f
+incdir+hw/rtl
hw/rtl/u8r_pkg.sv
hw/rtl/u8r_front.sv
hw/rtl/u8r_queue.sv
hw/rtl/u8r_back.sv
hw/rtl/utf8_decoder_replace_unit.sv
test/utf8_decoder_replace_unit_tb.sv
